// File: rtl/core/kcrs_pkg.sv
// ----------------------------------------------------------------------------
// kcrs_pkg: shared types and helpers for the region sign solver
// Sizes, payload structs, status codes, sequencer states and label arithmetic.
// ----------------------------------------------------------------------------
package kcrs_pkg;

  localparam int MAX_NODES = 16;
  localparam int LABELS    = 2 * MAX_NODES + 1;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = NODE_W + 1;
  localparam int LAB_W     = $clog2(LABELS);
  localparam int RGN_W     = LAB_W + 1;

  // Region sign codes as stored in the sign memory.
  localparam logic [1:0] SG_NONE  = 2'd0;
  localparam logic [1:0] SG_PLUS  = 2'd1;
  localparam logic [1:0] SG_MINUS = 2'd2;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_MALFORMED  = 2'd1,
    ST_WALK       = 2'd2,
    ST_NO_DIAGRAM = 2'd3
  } status_t;

  typedef struct packed {
    logic [5:0] even_partner;
    logic       crossing_negative;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [3:0] node_index;
    logic       region_sign_negative;
    logic       crossing_sign_negative;
    status_t    status;
    logic       last_result;
  } out_t;

  typedef enum logic [5:0] {
    S_LOAD, S_V_RD, S_V_CHK, S_V_MARK, S_INIT_RD, S_INIT_SET, S_SP_A, S_SP_B,
    S_RI_PASS, S_RI_NODE, S_RI_RD, S_RI_CHK, S_RI_MARK, S_IS_RD, S_IS_CHK,
    S_IL_TEST, S_IL_PT, S_IL_SS, S_IL_SL, S_RI_NEXT, S_CH_RD, S_CH_CHK,
    S_CH_NEXT, S_CS_INIT, S_CS_RD, S_CS_CHK, S_T_RD, S_T_CHK, S_AC_START,
    S_AC_DOWN, S_AC_CHK, S_FL_RD, S_FL_SIGN, S_FL_SET, S_FL_NEXT, S_OUT_RD,
    S_OUT_SET, S_OUT_WAIT
  } state_t;

  // Next label around the cycle of 1..nlab.
  function automatic logic [LAB_W-1:0] lab_nxt(input logic [LAB_W-1:0] l,
                                               input logic [LAB_W-1:0] nlab);
    return (l >= nlab) ? LAB_W'(1) : l + LAB_W'(1);
  endfunction

  function automatic logic [LAB_W-1:0] lab_prv(input logic [LAB_W-1:0] l,
                                               input logic [LAB_W-1:0] nlab);
    return (l <= LAB_W'(1)) ? nlab : l - LAB_W'(1);
  endfunction

  // True when label i lies on the arc from s to e, wrapping around.
  function automatic logic in_arc(input logic [LAB_W-1:0] i,
                                  input logic [LAB_W-1:0] s,
                                  input logic [LAB_W-1:0] e);
    if (e >= s) return (i >= s) && (i <= e);
    return (i >= s) || (i <= e);
  endfunction

  // Opposite sign code: plus and minus trade places.
  function automatic logic [1:0] sg_swap(input logic [1:0] c);
    return {c[0], c[1]};
  endfunction

endpackage

// File: rtl/core/knot_code_region_sign_solver_top.sv
// ----------------------------------------------------------------------------
// knot_code_region_sign_solver_top: region signs of a knot diagram from its code
// Loads a Dowker-Thistlethwaite code and solves the region sign of each node.
// ----------------------------------------------------------------------------
// Code entries are taken while loading; the solve then runs for a data
// dependent time, set by the single read port of each memory, through node
// checking, the inheritance passes with their cycle walks and loop scans, and
// the backtracking search with a walk of every region for each candidate.
// Each sign pair is written in two steps, S_SP_A then S_SP_B. Each result is
// held until the sink is ready, and the next is read only after it is taken.
// Reset (rst, synchronous) returns to loading with the sign and visit memories marked empty.
module knot_code_region_sign_solver_top
  import kcrs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // Sequencer registers.
  state_t state, state_next, ret_state, ret_state_next;
  logic [CNT_W-1:0] node_count, node_count_next, n, n_next, k, k_next;
  logic [CNT_W-1:0] depth, depth_next, count, count_next, total, total_next;
  logic overflow, overflow_next, in_loop, in_loop_next, again, again_next;
  logic [LAB_W-1:0] nlab, nlab_next, i_lab, i_lab_next, node, node_next;
  logic [LAB_W-1:0] start, start_next, stop, stop_next, lab, lab_next;
  logic [LAB_W-1:0] ptl, ptl_next, sp_l, sp_l_next, sp_p, sp_p_next;
  logic [LAB_W-1:0] tstart, tstart_next;
  logic [1:0] ss, ss_next, sp_code, sp_code_next;
  logic [RGN_W-1:0] regions, regions_next;
  logic tv, tv_next, tv0, tv0_next;
  logic out_valid_next;
  out_t out_data_next;

  // Partner memory: odd entries from the code, even entries filled on check.
  logic [LAB_W-1:0] part_mem [LABELS];
  logic p_we;
  logic [LAB_W-1:0] p_wa, p_wd, p_ra, p_rd;

  // Loaded crossing signs.
  logic cs_mem [MAX_NODES];
  logic cs_we, cs_wd, cs_rd;
  logic [NODE_W-1:0] cs_wa, cs_ra;

  // Region sign memory, with per-entry valid bits so a solve starts unsigned.
  logic [1:0] sg_mem [LABELS];
  logic [LABELS-1:0] sg_vld;
  logic sg_we, sg_clr, sg_rv;
  logic [LAB_W-1:0] sg_wa, sg_ra;
  logic [1:0] sg_wd, sg_rd, sg_rdv;

  // Visit mark memory, cleared at once through its valid bits.
  logic [1:0] vi_mem [LABELS];
  logic [LABELS-1:0] vi_vld;
  logic vi_we, vi_clr, vi_rv;
  logic [LAB_W-1:0] vi_wa, vi_ra;
  logic [1:0] vi_wd, vi_rd, vi_rdv;

  // Backtracking counter: {choice bit, node} per depth.
  logic [NODE_W:0] ch_mem [MAX_NODES];
  logic ch_we;
  logic [NODE_W-1:0] ch_wa, ch_ra;
  logic [NODE_W:0] ch_wd, ch_rd;

  // Memories. A read of the entry being written returns the new data.
  always_ff @(posedge clk) begin
    if (p_we) part_mem[p_wa] <= p_wd;
    p_rd <= (p_we && p_wa == p_ra) ? p_wd : part_mem[p_ra];
    if (cs_we) cs_mem[cs_wa] <= cs_wd;
    cs_rd <= (cs_we && cs_wa == cs_ra) ? cs_wd : cs_mem[cs_ra];
    if (sg_we) sg_mem[sg_wa] <= sg_wd;
    sg_rd <= (sg_we && sg_wa == sg_ra) ? sg_wd : sg_mem[sg_ra];
    sg_rv <= (sg_we && sg_wa == sg_ra) || sg_vld[sg_ra];
    if (vi_we) vi_mem[vi_wa] <= vi_wd;
    vi_rd <= (vi_we && vi_wa == vi_ra) ? vi_wd : vi_mem[vi_ra];
    vi_rv <= (vi_we && vi_wa == vi_ra) || vi_vld[vi_ra];
    if (ch_we) ch_mem[ch_wa] <= ch_wd;
    ch_rd <= (ch_we && ch_wa == ch_ra) ? ch_wd : ch_mem[ch_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sg_vld <= '0;
      vi_vld <= '0;
    end else begin
      if (sg_clr) sg_vld <= '0;
      if (sg_we) sg_vld[sg_wa] <= 1'b1;
      if (vi_clr) vi_vld <= '0;
      if (vi_we) vi_vld[vi_wa] <= 1'b1;
    end
  end

  // An entry not written since the last clear reads as zero (unsigned, unvisited).
  assign sg_rdv = sg_rv ? sg_rd : SG_NONE;
  assign vi_rdv = vi_rv ? vi_rd : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      node_count <= '0;
      overflow   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      node_count <= node_count_next;
      overflow   <= overflow_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ret_state <= ret_state_next;
    n <= n_next;             k <= k_next;           depth <= depth_next;
    count <= count_next;     total <= total_next;   in_loop <= in_loop_next;
    again <= again_next;     nlab <= nlab_next;     i_lab <= i_lab_next;
    node <= node_next;       start <= start_next;   stop <= stop_next;
    lab <= lab_next;         ptl <= ptl_next;       sp_l <= sp_l_next;
    sp_p <= sp_p_next;       tstart <= tstart_next; ss <= ss_next;
    sp_code <= sp_code_next; regions <= regions_next;
    tv <= tv_next;           tv0 <= tv0_next;       out_data <= out_data_next;
  end

  always_comb begin
    logic fail;
    logic [1:0] fail_code;
    logic [1:0] bit_m;
    logic [LAB_W-1:0] a_lab, nl, odd_lab;
    logic [CNT_W-1:0] n_eff;
    logic stored, ovf, nv;

    fail = 1'b0;           fail_code = ST_OK;
    bit_m = 2'd0;          a_lab = '0;   nl = '0;   nv = 1'b0;
    odd_lab = LAB_W'({k[NODE_W-1:0], 1'b1});
    stored = node_count < CNT_W'(MAX_NODES);
    ovf = overflow | ~stored;
    n_eff = node_count + CNT_W'(stored);

    state_next = state;       ret_state_next = ret_state;
    node_count_next = node_count; overflow_next = overflow;
    n_next = n;  k_next = k;  depth_next = depth;  count_next = count;
    total_next = total;  in_loop_next = in_loop;  again_next = again;
    nlab_next = nlab;  i_lab_next = i_lab;  node_next = node;
    start_next = start;  stop_next = stop;  lab_next = lab;  ptl_next = ptl;
    sp_l_next = sp_l;  sp_p_next = sp_p;  tstart_next = tstart;  ss_next = ss;
    sp_code_next = sp_code;  regions_next = regions;  tv_next = tv;  tv0_next = tv0;
    out_valid_next = out_valid;  out_data_next = out_data;

    in_ready = 1'b0;
    p_we = 1'b0;  p_wa = '0;  p_wd = '0;  p_ra = '0;
    cs_we = 1'b0; cs_wa = '0; cs_wd = 1'b0; cs_ra = '0;
    sg_we = 1'b0; sg_wa = '0; sg_wd = SG_NONE; sg_ra = '0; sg_clr = 1'b0;
    vi_we = 1'b0; vi_wa = '0; vi_wd = 2'd0; vi_ra = '0; vi_clr = 1'b0;
    ch_we = 1'b0; ch_wa = '0; ch_wd = '0; ch_ra = '0;

    unique case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (stored) begin
            p_we = 1'b1;
            p_wa = LAB_W'({node_count[NODE_W-1:0], 1'b1});
            p_wd = in_data.even_partner;
            cs_we = 1'b1;
            cs_wa = node_count[NODE_W-1:0];
            cs_wd = in_data.crossing_negative;
            node_count_next = node_count + CNT_W'(1);
          end else begin
            overflow_next = 1'b1;
          end
          if (in_data.last) begin
            node_count_next = '0;
            overflow_next = 1'b0;
            if (ovf || n_eff < CNT_W'(2)) begin
              fail = 1'b1;
              fail_code = ST_MALFORMED;
            end else begin
              n_next = n_eff;
              nlab_next = LAB_W'({n_eff, 1'b0});
              k_next = '0;
              sg_clr = 1'b1;
              vi_clr = 1'b1;
              state_next = S_V_RD;
            end
          end
        end
      end
      S_V_RD: begin
        p_ra = odd_lab;
        state_next = S_V_CHK;
      end
      S_V_CHK: begin
        if (p_rd == '0 || p_rd[0] || p_rd > nlab) begin
          fail = 1'b1;
          fail_code = ST_MALFORMED;
        end else begin
          vi_ra = p_rd;
          ptl_next = p_rd;
          state_next = S_V_MARK;
        end
      end
      S_V_MARK: begin
        if (vi_rdv != 2'd0) begin
          fail = 1'b1;
          fail_code = ST_MALFORMED;
        end else begin
          vi_we = 1'b1;  vi_wa = ptl;  vi_wd = 2'd1;
          p_we = 1'b1;   p_wa = ptl;   p_wd = odd_lab;
          k_next = k + CNT_W'(1);
          state_next = (k + CNT_W'(1) == n) ? S_INIT_RD : S_V_RD;
        end
      end
      S_INIT_RD: begin
        p_ra = LAB_W'(1);
        state_next = S_INIT_SET;
      end
      S_INIT_SET: begin
        sp_l_next = LAB_W'(1);
        sp_p_next = p_rd;
        sp_code_next = SG_PLUS;
        total_next = '0;
        ret_state_next = S_RI_PASS;
        state_next = S_SP_A;
      end
      S_SP_A: begin
        sg_we = 1'b1;  sg_wa = sp_l;  sg_wd = sp_code;
        state_next = S_SP_B;
      end
      S_SP_B: begin
        sg_we = 1'b1;  sg_wa = sp_p;  sg_wd = sg_swap(sp_code);
        state_next = ret_state;
      end
      S_RI_PASS: begin
        again_next = 1'b0;
        i_lab_next = LAB_W'(1);
        state_next = S_RI_NODE;
      end
      S_RI_NODE: begin
        vi_clr = 1'b1;
        node_next = i_lab;
        state_next = S_RI_RD;
      end
      S_RI_RD: begin
        vi_ra = node;
        p_ra = node;
        state_next = S_RI_CHK;
      end
      S_RI_CHK: begin
        if (vi_rdv != 2'd0) begin
          start_next = p_rd;
          state_next = S_IS_RD;
        end else begin
          ptl_next = p_rd;
          vi_ra = p_rd;
          state_next = S_RI_MARK;
        end
      end
      S_RI_MARK: begin
        if (vi_rdv != 2'd0) begin
          fail = 1'b1;
          fail_code = ST_WALK;
        end else begin
          vi_we = 1'b1;  vi_wa = ptl;  vi_wd = 2'd1;
          node_next = lab_nxt(node, nlab);
          state_next = S_RI_RD;
        end
      end
      S_IS_RD: begin
        p_ra = start;
        state_next = S_IS_CHK;
      end
      S_IS_CHK: begin
        stop_next = p_rd;
        if (lab_nxt(start, nlab) == p_rd || lab_nxt(p_rd, nlab) == start) begin
          fail = 1'b1;
          fail_code = ST_WALK;
        end else begin
          lab_next = lab_nxt(p_rd, nlab);
          in_loop_next = 1'b0;
          state_next = S_IL_TEST;
        end
      end
      S_IL_TEST: begin
        if (lab == start) begin
          state_next = S_RI_NEXT;
        end else begin
          p_ra = lab;
          state_next = S_IL_PT;
        end
      end
      S_IL_PT: begin
        ptl_next = p_rd;
        if (in_arc(p_rd, start, stop)) begin
          sg_ra = start;
          state_next = S_IL_SS;
        end else begin
          lab_next = lab_nxt(lab, nlab);
          state_next = S_IL_TEST;
        end
      end
      S_IL_SS: begin
        ss_next = sg_rdv;
        sg_ra = lab;
        state_next = S_IL_SL;
      end
      S_IL_SL: begin
        // At most one of the two spreads can fire: the first needs a signed
        // start, the second an unsigned one.
        in_loop_next = ~in_loop;
        lab_next = lab_nxt(lab, nlab);
        ret_state_next = S_IL_TEST;
        state_next = S_IL_TEST;
        if (ss != SG_NONE && sg_rdv == SG_NONE) begin
          sp_l_next = lab;
          sp_p_next = ptl;
          sp_code_next = in_loop ? sg_swap(ss) : ss;
          again_next = 1'b1;
          total_next = total + CNT_W'(1);
          state_next = S_SP_A;
        end else if (ss == SG_NONE && sg_rdv != SG_NONE) begin
          sp_l_next = start;
          sp_p_next = stop;
          sp_code_next = in_loop ? sg_swap(sg_rdv) : sg_rdv;
          again_next = 1'b1;
          total_next = total + CNT_W'(1);
          state_next = S_SP_A;
        end
      end
      S_RI_NEXT: begin
        if (i_lab == nlab) begin
          k_next = '0;
          if (again) begin
            state_next = S_RI_PASS;
          end else if (total < n - CNT_W'(1)) begin
            depth_next = '0;
            state_next = S_CH_RD;
          end else begin
            state_next = S_OUT_RD;
          end
        end else begin
          i_lab_next = i_lab + LAB_W'(1);
          state_next = S_RI_NODE;
        end
      end
      S_CH_RD: begin
        sg_ra = odd_lab;
        p_ra = odd_lab;
        state_next = S_CH_CHK;
      end
      S_CH_CHK: begin
        if (sg_rdv != SG_NONE) begin
          state_next = S_CH_NEXT;
        end else begin
          ch_we = 1'b1;
          ch_wa = depth[NODE_W-1:0];
          ch_wd = {1'b0, k[NODE_W-1:0]};
          depth_next = depth + CNT_W'(1);
          sp_l_next = odd_lab;
          sp_p_next = p_rd;
          sp_code_next = SG_PLUS;
          ret_state_next = S_CH_NEXT;
          state_next = S_SP_A;
        end
      end
      S_CH_NEXT: begin
        if (k + CNT_W'(1) == n) begin
          count_next = depth;
          state_next = S_CS_INIT;
        end else begin
          k_next = k + CNT_W'(1);
          state_next = S_CH_RD;
        end
      end
      S_CS_INIT: begin
        vi_clr = 1'b1;
        regions_next = '0;
        i_lab_next = LAB_W'(1);
        state_next = S_CS_RD;
      end
      S_CS_RD: begin
        vi_ra = i_lab;
        state_next = S_CS_CHK;
      end
      S_CS_CHK: begin
        if (vi_rdv != 2'd3) begin
          regions_next = regions + RGN_W'(1);
          tstart_next = i_lab;
          lab_next = i_lab;
          tv0_next = (vi_rdv == 2'd0 || vi_rdv == 2'd2);
          tv_next = (vi_rdv == 2'd0 || vi_rdv == 2'd2);
          state_next = S_T_RD;
        end else if (i_lab == nlab) begin
          k_next = '0;
          state_next = (regions == RGN_W'(n) + RGN_W'(2)) ? S_OUT_RD : S_AC_START;
        end else begin
          i_lab_next = i_lab + LAB_W'(1);
          state_next = S_CS_RD;
        end
      end
      S_T_RD: begin
        a_lab = tv ? lab : lab_prv(lab, nlab);
        vi_ra = lab;
        sg_ra = a_lab;
        p_ra = a_lab;
        state_next = S_T_CHK;
      end
      S_T_CHK: begin
        bit_m = tv ? 2'b01 : 2'b10;
        if ((vi_rdv & bit_m) != 2'd0) begin
          state_next = S_AC_START;
        end else begin
          vi_we = 1'b1;  vi_wa = lab;  vi_wd = vi_rdv | bit_m;
          if (tv) begin
            nl = (sg_rdv == SG_PLUS) ? lab_nxt(p_rd, nlab) : p_rd;
            nv = (sg_rdv == SG_PLUS);
          end else begin
            nl = (sg_rdv == SG_PLUS) ? p_rd : lab_nxt(p_rd, nlab);
            nv = (sg_rdv != SG_PLUS);
          end
          lab_next = nl;
          tv_next = nv;
          state_next = (nl == tstart && nv == tv0) ? S_CS_RD : S_T_RD;
        end
      end
      S_AC_START: begin
        depth_next = count;
        state_next = S_AC_DOWN;
      end
      S_AC_DOWN: begin
        if (depth == '0) begin
          fail = 1'b1;
          fail_code = ST_NO_DIAGRAM;
        end else begin
          depth_next = depth - CNT_W'(1);
          ch_ra = NODE_W'(depth - CNT_W'(1));
          state_next = S_AC_CHK;
        end
      end
      S_AC_CHK: begin
        state_next = ch_rd[NODE_W] ? S_AC_DOWN : S_FL_RD;
      end
      S_FL_RD: begin
        ch_ra = depth[NODE_W-1:0];
        state_next = S_FL_SIGN;
      end
      S_FL_SIGN: begin
        ch_we = 1'b1;
        ch_wa = depth[NODE_W-1:0];
        ch_wd = {~ch_rd[NODE_W], ch_rd[NODE_W-1:0]};
        lab_next = LAB_W'({ch_rd[NODE_W-1:0], 1'b1});
        sg_ra = LAB_W'({ch_rd[NODE_W-1:0], 1'b1});
        p_ra = LAB_W'({ch_rd[NODE_W-1:0], 1'b1});
        state_next = S_FL_SET;
      end
      S_FL_SET: begin
        sp_l_next = lab;
        sp_p_next = p_rd;
        sp_code_next = sg_swap(sg_rdv);
        ret_state_next = S_FL_NEXT;
        state_next = S_SP_A;
      end
      S_FL_NEXT: begin
        if (depth + CNT_W'(1) == count) begin
          state_next = S_CS_INIT;
        end else begin
          depth_next = depth + CNT_W'(1);
          state_next = S_FL_RD;
        end
      end
      S_OUT_RD: begin
        sg_ra = odd_lab;
        cs_ra = k[NODE_W-1:0];
        state_next = S_OUT_SET;
      end
      S_OUT_SET: begin
        out_data_next.node_index = 4'(k[NODE_W-1:0]);
        out_data_next.region_sign_negative = (sg_rdv == SG_MINUS);
        out_data_next.crossing_sign_negative = cs_rd;
        out_data_next.status = ST_OK;
        out_data_next.last_result = (k + CNT_W'(1) == n);
        out_valid_next = 1'b1;
        state_next = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (out_ready) begin
          out_valid_next = 1'b0;
          if (out_data.last_result) begin
            state_next = S_LOAD;
          end else begin
            k_next = k + CNT_W'(1);
            state_next = S_OUT_RD;
          end
        end
      end
      default: state_next = S_LOAD;
    endcase

    // A failed run ends in a single transaction carrying only its status.
    if (fail) begin
      out_data_next.node_index = '0;
      out_data_next.region_sign_negative = 1'b0;
      out_data_next.crossing_sign_negative = 1'b0;
      out_data_next.status = status_t'(fail_code);
      out_data_next.last_result = 1'b1;
      out_valid_next = 1'b1;
      state_next = S_OUT_WAIT;
    end
  end

  // The block never takes a code entry while a result is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  // The final code entry starts a solve or a failure result; loading stops right after it.
  a_last_stops_load: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.last) |=> !in_ready)
    else $error("loading continued after the final entry");

  // A failure status is always the only and final transaction of a run.
  a_fail_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != ST_OK) |-> out_data.last_result)
    else $error("failure result not marked final");

  // Only real signs are ever written into the sign memory.
  a_sign_written: assert property (@(posedge clk) disable iff (rst)
    sg_we |-> (sg_wd == SG_PLUS || sg_wd == SG_MINUS))
    else $error("unsigned code written to the sign memory");

  // The load counter never runs past the node capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    node_count <= CNT_W'(MAX_NODES))
    else $error("node counter overran");

endmodule

// File: verif/knot_code_region_sign_solver_top_test.sv
// ----------------------------------------------------------------------------
// knot_code_region_sign_solver_top_test: self-checking bench for the solver
// Feeds directed and random knot codes, predicts every region sign and status
// in a behavioral model of the solve, and checks each output transaction.
// ----------------------------------------------------------------------------
module knot_code_region_sign_solver_top_test;
  import kcrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 20000000;
  localparam int NLAB_MAX    = 2 * MAX_NODES + 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  knot_code_region_sign_solver_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // 8 ns clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Code entries waiting to be offered, and node results still to arrive.
  in_t  entry_q[$];
  out_t sign_results_q[$];
  int   error_count = 0;
  bit   in_taken = 1'b0;
  bit   quiet = 1'b0;
  bit   sink_block_req = 1'b0;
  int   sink_block_left = 0;
  int   src_gap = 0;
  int   sink_gap = 0;
  int   cycle_count = 0;

  // --------------------------------------------------------------------------
  // Behavioral model of the solver. Labels run 1..2n around the knot; the
  // sign table holds 0 for unsigned, 1 for plus and 2 for minus.
  // --------------------------------------------------------------------------
  int unsigned partner_lab[NLAB_MAX];
  bit          cross_neg[MAX_NODES];
  int unsigned sign_tab[NLAB_MAX];
  int unsigned marks[NLAB_MAX];
  bit          flip_bits[MAX_NODES];
  int unsigned flip_nodes[MAX_NODES];
  int unsigned flip_depth = 0;
  int unsigned flip_count = 0;
  int unsigned loaded = 0;
  bit          too_many = 1'b0;
  int unsigned label_count = 2;
  bit          cycle_fault = 1'b0;

  function automatic int unsigned lnext(int unsigned l);
    return (l >= label_count) ? 1 : l + 1;
  endfunction

  function automatic int unsigned lprev(int unsigned l);
    return (l <= 1) ? label_count : l - 1;
  endfunction

  function automatic int unsigned mate(int unsigned l);
    return partner_lab[l % NLAB_MAX] % NLAB_MAX;
  endfunction

  function automatic int sign_of(int unsigned l);
    int unsigned v;
    v = sign_tab[l % NLAB_MAX];
    return (v == 1) ? 1 : ((v == 2) ? -1 : 0);
  endfunction

  function automatic void sign_pair(int unsigned l, int s);
    sign_tab[l % NLAB_MAX] = (s > 0) ? 1 : 2;
    sign_tab[mate(l)] = (s > 0) ? 2 : 1;
  endfunction

  function automatic int unsigned try_sign(int s, int unsigned l);
    if (s == 0 || sign_of(l) != 0) return 0;
    sign_pair(l, s);
    return 1;
  endfunction

  function automatic bit on_arc(int unsigned i, int unsigned s, int unsigned e);
    if (e >= s) return (i >= s) && (i <= e);
    return (i >= s) || (i <= e);
  endfunction

  // Propagates signs from the loop that starts and ends at one crossing.
  function automatic int unsigned loop_signs(int unsigned start);
    int unsigned stop, l, gained;
    bit within_loop;
    int k;
    stop = mate(start);
    gained = 0;
    within_loop = 1'b0;
    if (lnext(start) == mate(start) || lnext(stop) == mate(stop)) begin
      cycle_fault = 1'b1;
      return 0;
    end
    for (l = lnext(stop); l != start; l = lnext(l)) begin
      if (on_arc(mate(l), start, stop)) begin
        k = within_loop ? -1 : 1;
        gained += try_sign(k * sign_of(start), l);
        gained += try_sign(k * sign_of(l), start);
        within_loop = !within_loop;
      end
    end
    return gained;
  endfunction

  function automatic int unsigned propagate_signs();
    int unsigned total, i, node, g;
    bit again;
    total = 0;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      for (i = 1; i <= label_count; i++) begin
        foreach (marks[j]) marks[j] = 0;
        node = i;
        forever begin
          if (marks[node] != 0) begin
            g = loop_signs(mate(node));
            if (cycle_fault) return total;
            if (g != 0) again = 1'b1;
            total += g;
            break;
          end
          if (marks[mate(node)] != 0) begin
            cycle_fault = 1'b1;
            return total;
          end
          marks[mate(node)] = 1;
          node = lnext(node);
        end
      end
    end
    return total;
  endfunction

  // Binary counter over the free nodes; a carry flips every lower choice.
  function automatic bit next_candidate();
    int unsigned d;
    bit found;
    d = flip_count;
    found = 1'b0;
    while (d > 0) begin
      d--;
      if (!flip_bits[d]) begin
        found = 1'b1;
        break;
      end
    end
    if (!found) return 1'b0;
    for (; d < flip_count; d++) begin
      flip_bits[d] ^= 1'b1;
      sign_pair(2 * flip_nodes[d] + 1, -sign_of(2 * flip_nodes[d] + 1));
    end
    flip_depth = flip_count;
    return 1'b1;
  endfunction

  // Walks one region; fails when a side is walked twice in one direction.
  function automatic bit walk_region(int unsigned start, int v0);
    int unsigned l, p, bitv;
    int v;
    l = start;
    v = v0;
    forever begin
      bitv = (v > 0) ? 1 : 2;
      if ((marks[l] & bitv) != 0) return 1'b0;
      marks[l] |= bitv;
      if (v > 0) begin
        if (sign_of(l) > 0) l = lnext(mate(l));
        else begin
          v = -v;
          l = mate(l);
        end
      end else begin
        p = lprev(l);
        if (sign_of(p) > 0) l = mate(p);
        else begin
          v = -v;
          l = lnext(mate(p));
        end
      end
      if (l == start && v == v0) return 1'b1;
    end
  endfunction

  function automatic bit planar_ok(int unsigned n);
    int unsigned regions, i;
    regions = 0;
    foreach (marks[j]) marks[j] = 0;
    forever begin
      for (i = 1; i <= label_count; i++)
        if (marks[i] < 3) break;
      if (i > label_count) break;
      regions++;
      if (!walk_region(i, (marks[i] == 0 || marks[i] == 2) ? 1 : -1)) return 1'b0;
    end
    return regions == n + 2;
  endfunction

  function automatic status_t solve_code(int unsigned n);
    int unsigned k, v, total, lab;
    if (too_many || n < 2) return ST_MALFORMED;
    label_count = 2 * n;
    foreach (sign_tab[j]) sign_tab[j] = 0;
    foreach (marks[j]) marks[j] = 0;
    for (k = 0; k < n; k++) begin
      v = partner_lab[2 * k + 1];
      if (v == 0 || v[0] || v > label_count || marks[v] != 0) return ST_MALFORMED;
      marks[v] = 1;
      partner_lab[v] = 2 * k + 1;
    end
    sign_pair(1, 1);
    cycle_fault = 1'b0;
    total = propagate_signs();
    if (cycle_fault) return ST_WALK;
    if (total < n - 1) begin
      flip_depth = 0;
      for (k = 0; k < n; k++) begin
        lab = 2 * k + 1;
        if (sign_of(lab) != 0) continue;
        if (flip_depth < MAX_NODES) begin
          flip_bits[flip_depth] = 1'b0;
          flip_nodes[flip_depth] = k;
          flip_depth++;
        end
        sign_pair(lab, 1);
      end
      flip_count = flip_depth;
      while (!planar_ok(n))
        if (!next_candidate()) return ST_NO_DIAGRAM;
    end
    return ST_OK;
  endfunction

  // Loads one code entry and, on the final one, queues the node results.
  function automatic void load_entry(in_t e);
    int unsigned n;
    status_t st;
    out_t r;
    if (loaded < MAX_NODES) begin
      partner_lab[2 * loaded + 1] = 32'(e.even_partner);
      cross_neg[loaded] = e.crossing_negative;
      loaded++;
    end else too_many = 1'b1;
    if (!e.last) return;
    n = loaded;
    st = solve_code(n);
    loaded = 0;
    too_many = 1'b0;
    flip_depth = 0;
    if (st != ST_OK) begin
      r = '0;
      r.status = st;
      r.last_result = 1'b1;
      sign_results_q.push_back(r);
      return;
    end
    for (int unsigned k = 0; k < n; k++) begin
      r.node_index = k[3:0];
      r.region_sign_negative = sign_of(2 * k + 1) < 0;
      r.crossing_sign_negative = cross_neg[k];
      r.status = ST_OK;
      r.last_result = (k + 1 == n);
      sign_results_q.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Code generation. Each list of partners becomes one code, the final entry
  // flagged last, with random crossing signs.
  // --------------------------------------------------------------------------
  task automatic push_code(input int unsigned partners[$]);
    in_t e;
    foreach (partners[i]) begin
      e.even_partner = partners[i][5:0];
      e.crossing_negative = 1'($urandom_range(0, 1));
      e.last = (i == partners.size() - 1);
      entry_q.push_back(e);
    end
  endtask

  // A well-formed code: a random pairing of the odd labels with 2..2n.
  task automatic push_wellformed(input int unsigned n);
    int unsigned p[$];
    int unsigned j, t;
    for (int unsigned i = 1; i <= n; i++) p.push_back(2 * i);
    for (int unsigned i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = p[i];
      p[i] = p[j];
      p[j] = t;
    end
    push_code(p);
  endtask

  // A broken code: one entry replaced by noise over the full field range.
  task automatic push_broken(input int unsigned n);
    int unsigned p[$];
    for (int unsigned i = 1; i <= n; i++) p.push_back(2 * i);
    p[$urandom_range(0, n - 1)] = $urandom_range(0, 63);
    push_code(p);
  endtask

  // Waits until every offered entry is taken and every result has arrived.
  task automatic drain();
    while (entry_q.size() != 0 || in_valid || sign_results_q.size() != 0)
      @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Source side: a new entry is presented at the falling edge only when the
  // previous one was taken at the last rising edge, or nothing was offered.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      src_gap <= 0;
    end else if (!in_valid || in_taken) begin
      if (src_gap != 0) begin
        in_valid <= 1'b0;
        src_gap <= src_gap - 1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        in_valid <= 1'b0;
        src_gap <= $urandom_range(0, 18);
      end else if (entry_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= entry_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long sink hold-off, counted in cycles here so the source keeps running.
  always @(posedge clk) begin
    if (sink_block_req) sink_block_left <= 400;
    else if (sink_block_left != 0) sink_block_left <= sink_block_left - 1;
  end

  // Sink side: ready drops in random bursts, or through the long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_gap <= 0;
    end else if (sink_block_left != 0) begin
      out_ready <= 1'b0;
    end else if (sink_gap != 0) begin
      out_ready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_ready <= 1'b0;
      sink_gap <= $urandom_range(0, 18);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every input transaction feeds the model, every output
  // transaction is checked against the oldest predicted result.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) load_entry(in_data);
      if (out_valid && out_ready) begin
        if (sign_results_q.size() == 0) begin
          report_mismatch("unexpected result, node_index", 32'(out_data.node_index), 0);
        end else begin
          want = sign_results_q.pop_front();
          if (out_data.node_index !== want.node_index)
            report_mismatch("node_index", 32'(out_data.node_index),
                            32'(want.node_index));
          if (out_data.region_sign_negative !== want.region_sign_negative)
            report_mismatch("region_sign_negative", 32'(out_data.region_sign_negative),
                            32'(want.region_sign_negative));
          if (out_data.crossing_sign_negative !== want.crossing_sign_negative)
            report_mismatch("crossing_sign_negative",
                            32'(out_data.crossing_sign_negative),
                            32'(want.crossing_sign_negative));
          if (out_data.status !== want.status)
            report_mismatch("status", 32'(out_data.status), 32'(want.status));
          if (out_data.last_result !== want.last_result)
            report_mismatch("last_result", 32'(out_data.last_result),
                            32'(want.last_result));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("knot_code_region_sign_solver_top_test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequence.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned sent;
    int unsigned n;
    int unsigned p[$];
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed codes: a lone entry, the trefoil and figure eight, a tight
    // loop, zero, odd, out of range and repeated partners.
    p = {2};             push_code(p);
    p = {4, 6, 2};       push_code(p);
    p = {4, 6, 8, 2};    push_code(p);
    p = {2, 4};          push_code(p);
    p = {0, 2};          push_code(p);
    p = {4, 3};          push_code(p);
    p = {63, 2};         push_code(p);
    p = {32, 4};         push_code(p);
    p = {2, 2};          push_code(p);
    drain();

    // Too many entries: seventeen entries, one beyond the table.
    p.delete();
    for (int i = 0; i < 17; i++) p.push_back(2 * ((i % 16) + 1));
    push_code(p);
    // A full sixteen-node code with a repeated partner.
    p.delete();
    for (int i = 0; i < 16; i++) p.push_back(2 * ((i + 1) % 15 + 1));
    push_code(p);
    drain();

    // Long sink hold-off while the source keeps offering codes.
    @(negedge clk) sink_block_req = 1'b1;
    @(negedge clk) sink_block_req = 1'b0;
    for (int i = 0; i < 8; i++) push_wellformed($urandom_range(2, 4));
    drain();

    // Random part: mostly well-formed codes with random pairings.
    sent = 0;
    while (sent < 180) begin
      if (sent > 140) quiet = 1'b1;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 8) : $urandom_range(2, 6);
      case ($urandom_range(0, 9))
        0, 1: push_broken(n);
        2: begin
          p.delete();
          n = $urandom_range(1, 20);
          for (int i = 0; i < n; i++) p.push_back($urandom_range(0, 63));
          push_code(p);
        end
        default: push_wellformed(n);
      endcase
      sent += n;
      // Now and then the source waits for every result before moving on.
      if ($urandom_range(0, 15) == 0) drain();
    end
    drain();
    repeat (200) @(posedge clk);

    if (error_count == 0) $display("knot_code_region_sign_solver_top_test passed");
    else $display("knot_code_region_sign_solver_top_test failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/kcrs_pkg.sv
rtl/core/knot_code_region_sign_solver_top.sv
verif/knot_code_region_sign_solver_top_test.sv
